[rtl/core/mps_pkg.sv]
// ----------------------------------------------------------------------------
// mps_pkg: shared types and constants for the microprogram sequencer slice
// Word and stack sizes, pin event codes, source select codes, item structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

    localparam int WORD_BITS     = 4;
    localparam int STACK_ENTRIES = 4;

    // Level counts 0..STACK_ENTRIES; pointer addresses one entry.
    localparam int LEVEL_BITS = $clog2(STACK_ENTRIES + 1);
    localparam int PTR_BITS   = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

    // Clock event codes; the fourth code means no event.
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_RISE = 2'd1;
    localparam logic [1:0] MODE_FALL = 2'd2;

    // Address source codes.
    localparam logic [1:0] SRC_COUNTER = 2'd0;
    localparam logic [1:0] SRC_AREG    = 2'd1;
    localparam logic [1:0] SRC_STACK   = 2'd2;
    localparam logic [1:0] SRC_DIRECT  = 2'd3;

    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [LEVEL_BITS-1:0] t_level;
    typedef logic [PTR_BITS-1:0]   t_ptr;

    typedef struct packed {
        logic [1:0] mode;
        logic       re_fall;
        logic       carry_in;
        logic       push_pop;
        logic       stack_hold;
        logic [1:0] source_sel;
        t_word      addr_in;
        t_word      direct_in;
        t_word      or_in;
        logic       za_active;
        logic       oe_active;
    } t_in_item;

    typedef struct packed {
        t_word y;
        logic  carry_out;
    } t_out_item;

endpackage : mps_pkg

`default_nettype wire

[rtl/core/microprogram_sequencer_slice_top.sv]
// ----------------------------------------------------------------------------
// microprogram_sequencer_slice_top: 4-bit microprogram sequencer slice
// Takes one pin event per item and returns the driven address word and the
// counter wrap flag after that event.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                         | payload
//  --------+-----------+-----------------------------------+-----------
//  in      | input     | i_in_valid / o_in_stall           | i_in_item
//  out     | output    | o_out_valid / i_out_stall         | o_out_item
//
//  Every item passes from acceptance through the input register, then
//  through the event logic into the result register. A new item is
//  accepted every cycle unless the input side stalls; the state (counter,
//  address register, stack, latched pop, held outputs) is updated in the
//  same edge that loads the result, so the next item always sees it.
//  A stalled result holds the result register and the input register; the
//  input side stalls only while both are full. Reset (synchronous, active
//  low) empties both stages and clears all control state; the stack entries
//  themselves are not cleared.
//
`default_nettype none

module microprogram_sequencer_slice_top (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  mps_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output mps_pkg::t_out_item o_out_item,
    input  wire                i_out_stall
);
    import mps_pkg::*;

    // Pipeline control
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;     // input stage moves into the result stage
    logic      fire;        // an item is processed this cycle

    // Sequencer state
    t_word  r_counter, n_counter;
    t_word  r_addr, n_addr;
    t_word  r_stack [STACK_ENTRIES];
    t_level r_level, n_level;
    t_word  r_popped, n_popped;
    logic   r_popped_valid, n_popped_valid;
    t_word  r_y, n_y;
    logic   r_carry, n_carry;

    // Stack write request
    logic   push_en;
    t_ptr   push_ptr;

    // Working values
    logic   forced;
    t_word  top_val;
    t_word  src_val;
    t_level top_idx;

    // Advance whenever the result slot is empty or being taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Event logic for the item in the input register
    always_comb begin
        n_counter      = r_counter;
        n_carry        = r_carry;
        n_addr         = r_addr;
        n_level        = r_level;
        n_popped       = r_popped;
        n_popped_valid = r_popped_valid;
        n_y            = r_y;
        push_en        = 1'b0;
        push_ptr       = r_level[PTR_BITS-1:0];
        top_idx        = '0;
        top_val        = '0;
        src_val        = '0;

        // Rising clock with carry in: count, flag the wrap.
        if (r_in.mode == MODE_RISE && r_in.carry_in) begin
            if (r_counter == '1) begin
                n_counter = '0;
                n_carry   = 1'b1;
            end else begin
                n_counter = r_counter + 1'b1;
                n_carry   = 1'b0;
            end
        end

        // Falling register enable: load the address register.
        if (r_in.re_fall) begin
            n_addr = r_in.addr_in;
        end

        forced = !r_in.za_active || r_in.oe_active;

        if (forced) begin
            n_y = '0;
        end else if (r_in.mode == MODE_FALL) begin
            // Stack first: push the counter or pop into the latch.
            if (!r_in.stack_hold) begin
                if (r_in.push_pop) begin
                    if (r_level < LEVEL_BITS'(STACK_ENTRIES)) begin
                        push_en = 1'b1;
                        n_level = r_level + 1'b1;
                    end
                end else if (r_level != '0) begin
                    n_level        = r_level - 1'b1;
                    top_idx        = r_level - 1'b1;
                    n_popped       = r_stack[top_idx[PTR_BITS-1:0]];
                    n_popped_valid = 1'b1;
                end
            end

            // Top of stack after the update; a fresh push is not in the array yet.
            if (push_en) begin
                top_val = n_counter;
            end else if (n_level != '0) begin
                top_idx = n_level - 1'b1;
                top_val = r_stack[top_idx[PTR_BITS-1:0]];
            end

            unique case (r_in.source_sel)
                SRC_COUNTER: src_val = n_counter;
                SRC_AREG:    src_val = n_addr;
                SRC_STACK: begin
                    // Hand out a latched pop once, then drop it.
                    if (n_popped_valid) begin
                        src_val        = n_popped;
                        n_popped_valid = 1'b0;
                    end else begin
                        src_val = top_val;
                    end
                end
                SRC_DIRECT:  src_val = r_in.direct_in;
                default:     src_val = '0;
            endcase

            n_y       = src_val | r_in.or_in;
            n_counter = n_y;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Result register and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_counter      <= '0;
            r_addr         <= '0;
            r_level        <= '0;
            r_popped       <= '0;
            r_popped_valid <= 1'b0;
            r_y            <= '0;
            r_carry        <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_counter      <= n_counter;
                r_addr         <= n_addr;
                r_level        <= n_level;
                r_popped       <= n_popped;
                r_popped_valid <= n_popped_valid;
                r_y            <= n_y;
                r_carry        <= n_carry;
            end
        end
        if (fire) begin
            r_out.y         <= n_y;
            r_out.carry_out <= n_carry;
        end
    end

    // Stack entries: no reset, only written entries are read.
    // A push happens only on a falling clock, so the counter before the
    // source update is the current register value.
    always_ff @(posedge i_clk) begin
        if (fire && push_en) begin
            r_stack[push_ptr] <= r_counter;
        end
    end

endmodule : microprogram_sequencer_slice_top

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the microprogram sequencer slice
// Feeds pin events through the valid/stall input channel, mirrors the
// counter, address register, stack and latched pop in a local model, and
// checks every returned address word and wrap flag in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import mps_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;

    always #2 clk = ~clk;

    microprogram_sequencer_slice_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    // Pin events waiting to be offered, and the address/flag pairs the
    // slice still owes us, oldest first.
    t_in_item  pin_events[$];
    t_out_item due_outputs[$];
    int        errors    = 0;

    // Set at a rising edge when that channel moved an item.
    logic      in_taken  = 1'b0;
    logic      out_taken = 1'b0;

    // ------------------------------------------------------------------
    // Local copy of the sequencer state. Reset happens once, so the
    // declaration values stand in for the reset values.
    // ------------------------------------------------------------------
    t_word upc_cnt    = '0;
    t_word addr_reg   = '0;
    t_word lifo[STACK_ENTRIES];
    int    lifo_depth = 0;
    t_word pop_word   = '0;
    logic  pop_held   = 1'b0;
    t_word y_drive    = '0;
    logic  wrap_flag  = 1'b0;

    // Apply one pin event to the local state and return what the slice
    // should drive afterwards.
    function automatic t_out_item sequence_event(input t_in_item ev);
        t_word     pick;
        t_out_item res;
        // Counting rising edge: wrap from all ones sets the flag,
        // any other count clears it. No carry_in leaves both alone.
        if (ev.mode == MODE_RISE && ev.carry_in) begin
            wrap_flag = (upc_cnt == '1);
            upc_cnt   = upc_cnt + 1'b1;
        end
        // The register load lands even when the output is forced.
        if (ev.re_fall) begin
            addr_reg = ev.addr_in;
        end
        if (!ev.za_active || ev.oe_active) begin
            y_drive = '0;
        end else if (ev.mode == MODE_FALL) begin
            if (!ev.stack_hold) begin
                if (ev.push_pop) begin
                    // Push on a full stack is dropped.
                    if (lifo_depth < STACK_ENTRIES) begin
                        lifo[lifo_depth] = upc_cnt;
                        lifo_depth++;
                    end
                end else if (lifo_depth > 0) begin
                    // Pop into the latch; a pop on empty keeps the latch.
                    lifo_depth--;
                    pop_word = lifo[lifo_depth];
                    pop_held = 1'b1;
                end
            end
            case (ev.source_sel)
                SRC_COUNTER: pick = upc_cnt;
                SRC_AREG:    pick = addr_reg;
                SRC_STACK: begin
                    // The latched pop is handed out once, then the top.
                    if (pop_held) begin
                        pick     = pop_word;
                        pop_held = 1'b0;
                    end else begin
                        pick = (lifo_depth == 0) ? t_word'(0) : lifo[lifo_depth - 1];
                    end
                end
                default:     pick = ev.direct_in;
            endcase
            pick    = pick | ev.or_in;
            upc_cnt = pick;
            y_drive = pick;
        end
        res.y         = y_drive;
        res.carry_out = wrap_flag;
        return res;
    endfunction

    function automatic t_in_item pin(input logic [1:0] code, input logic re,
                                     input logic ci, input logic pp,
                                     input logic hold, input logic [1:0] sel,
                                     input t_word a, input t_word d, input t_word o,
                                     input logic za, input logic oe);
        t_in_item ev;
        ev.mode       = code;
        ev.re_fall    = re;
        ev.carry_in   = ci;
        ev.push_pop   = pp;
        ev.stack_hold = hold;
        ev.source_sel = sel;
        ev.addr_in    = a;
        ev.direct_in  = d;
        ev.or_in      = o;
        ev.za_active  = za;
        ev.oe_active  = oe;
        return ev;
    endfunction

    // Random pin event: mostly real clock edges with the output enabled, so
    // the stack and counter get exercised; the rest is idle codes and forcing.
    function automatic t_in_item random_event();
        logic [31:0] raw;
        t_in_item    ev;
        raw = $urandom;
        ev  = raw[$bits(t_in_item)-1:0];
        case ($urandom_range(0, 9))
            0:       ;
            1, 2, 3: ev.mode = MODE_RISE;
            default: ev.mode = MODE_FALL;
        endcase
        if ($urandom_range(0, 7) != 0) begin
            ev.za_active = 1'b1;
            ev.oe_active = 1'b0;
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Rising edge: note handshakes, predict accepted events, check results.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        in_taken  <= rst_n && in_valid && !in_stall;
        out_taken <= rst_n && out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall) begin
            if (due_outputs.size() == 0) begin
                errors++;
                if (errors < 40) begin
                    $display("%0t: unexpected item y=%h carry=%b", $time,
                             out_item.y, out_item.carry_out);
                end
            end else begin
                want = due_outputs.pop_front();
                if (out_item.y !== want.y) begin
                    errors++;
                    if (errors < 40) begin
                        $display("%0t: y expected %h actual %h", $time,
                                 want.y, out_item.y);
                    end
                end
                if (out_item.carry_out !== want.carry_out) begin
                    errors++;
                    if (errors < 40) begin
                        $display("%0t: carry_out expected %b actual %b", $time,
                                 want.carry_out, out_item.carry_out);
                    end
                end
            end
        end
        if (rst_n && in_valid && !in_stall) begin
            due_outputs.push_back(sequence_event(in_item));
        end
    end

    // ------------------------------------------------------------------
    // Sender: falling edge. Hold a stalled item; after each accepted item
    // draw a random idle gap, with calm stretches of back-to-back items.
    // ------------------------------------------------------------------
    int   send_gap  = 0;
    int   send_left = 0;
    logic send_calm = 1'b0;

    always @(negedge clk) begin
        if (rst_n && !(in_valid && !in_taken)) begin
            if (in_taken) begin
                if (send_left == 0) begin
                    send_left = $urandom_range(16, 64);
                    send_calm = ($urandom_range(0, 2) == 0);
                end
                send_left--;
                send_gap = send_calm ? 0 : $urandom_range(0, 7);
            end
            if (send_gap > 0 || pin_events.size() == 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end
                in_valid <= 1'b0;
            end else begin
                in_item  <= pin_events.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: falling edge. Stall for a random gap after each result, with
    // calm stretches, and twice hold off for a long run of cycles so the
    // slice fills and pushes back on the sender.
    // ------------------------------------------------------------------
    int   recv_wait = 0;
    int   recv_left = 0;
    logic recv_calm = 1'b0;
    int   long_hold = 0;
    int   recv_seen = 0;

    always @(negedge clk) begin
        if (out_taken) begin
            recv_seen++;
            if (recv_left == 0) begin
                recv_left = $urandom_range(16, 64);
                recv_calm = ($urandom_range(0, 2) == 0);
            end
            recv_left--;
            recv_wait = recv_calm ? 0 : $urandom_range(0, 7);
            if (recv_seen == 300 || recv_seen == 1100) begin
                long_hold = 250;
            end
        end
        if (long_hold > 0) begin
            long_hold--;
            out_stall <= 1'b1;
        end else if (recv_wait > 0) begin
            recv_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        // Load all ones directly, then count through the wrap.
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 1, SRC_DIRECT, 0, 15, 0, 1, 0));
        pin_events.push_back(pin(MODE_RISE, 0, 1, 0, 1, SRC_COUNTER, 0, 0, 0, 1, 0));
        // Rising edge without carry_in: counter and flag hold.
        pin_events.push_back(pin(MODE_RISE, 0, 0, 0, 1, SRC_COUNTER, 0, 0, 0, 1, 0));
        // Unused clock code acts as no event; only the register loads.
        pin_events.push_back(pin(2'd3, 1, 1, 1, 0, SRC_STACK, 10, 0, 0, 1, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 1, SRC_AREG, 0, 0, 5, 1, 0));
        pin_events.push_back(pin(MODE_NONE, 1, 0, 0, 0, SRC_COUNTER, 15, 0, 0, 1, 0));
        // Fill the stack, then push once more while full.
        pin_events.push_back(pin(MODE_FALL, 0, 0, 1, 0, SRC_COUNTER, 0, 0, 0, 1, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 1, 0, SRC_DIRECT, 0, 3, 0, 1, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 1, 0, SRC_DIRECT, 0, 9, 4, 1, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 1, 0, SRC_DIRECT, 0, 0, 0, 1, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 1, 0, SRC_DIRECT, 0, 6, 0, 1, 0));
        // Held stack reads the top without popping.
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 1, SRC_STACK, 0, 0, 0, 1, 0));
        // Pop into the latch, then pop again over it and read it back.
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 0, SRC_COUNTER, 0, 0, 0, 1, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 0, SRC_STACK, 0, 0, 0, 1, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 1, SRC_STACK, 0, 0, 0, 1, 0));
        // Drain, then pop on empty: the latch survives and is read once.
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 0, SRC_DIRECT, 0, 1, 0, 1, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 0, SRC_DIRECT, 0, 2, 0, 1, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 0, SRC_STACK, 0, 0, 0, 1, 0));
        // Empty stack with nothing latched reads zero.
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 1, SRC_STACK, 0, 0, 0, 1, 0));
        // Forced output: count and load still land, stack update skipped.
        pin_events.push_back(pin(MODE_RISE, 1, 1, 0, 0, SRC_COUNTER, 7, 0, 0, 0, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 1, 0, SRC_AREG, 0, 0, 0, 1, 1));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 0, SRC_STACK, 0, 0, 0, 0, 1));
        pin_events.push_back(pin(MODE_FALL, 1, 1, 1, 1, SRC_DIRECT, 15, 15, 15, 1, 0));
        pin_events.push_back(pin(MODE_FALL, 0, 0, 0, 1, SRC_AREG, 0, 0, 0, 1, 0));

        repeat (1680) begin
            pin_events.push_back(random_event());
        end

        // Hold reset, then release it at a falling edge.
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every event accepted, every result returned, then settle.
        while (pin_events.size() != 0 || in_valid) @(posedge clk);
        while (due_outputs.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
